@@ rtl/core/sorted_store_upper_bound_count_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted store unit.
// Each macro expects clk and arst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef SORTED_STORE_UPPER_BOUND_COUNT_UNIT_MACROS_SVH
`define SORTED_STORE_UPPER_BOUND_COUNT_UNIT_MACROS_SVH

// Same-cycle implication.
`define SSUBC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSUBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ssubc_pkg.sv @@
// ----------------------------------------------------------------------------
// ssubc_pkg
// Types and constants shared by the sorted store unit and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ssubc_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned COUNT_W = 9;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

	// Flipping the sign bit makes unsigned order match signed order.
	localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

	typedef struct packed {
		logic vld;
		logic ins;
		logic qry;
		logic dropped;
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/ssubc_req_if.sv @@
// ----------------------------------------------------------------------------
// ssubc_req_if
// Request channel: one beat carries a function code and a value.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssubc_req_if;
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic signed [31:0]  value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/ssubc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ssubc_rsp_if
// Response channel: one beat carries a count and a dropped flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssubc_rsp_if;
	logic       valid;
	logic       ready;
	logic [8:0] count;
	logic       dropped;

	modport source (output valid, output count, output dropped, input ready);
	modport sink (input valid, input count, input dropped, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sorted_store_upper_bound_count_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_store_upper_bound_count_unit
// Sorted store of signed 32-bit values with insert, upper-bound count and
// clear, built as a chain of CAPACITY compare cells.
// ----------------------------------------------------------------------------
// Requests arrive on req (func, value) and each one produces exactly one
// beat on rsp (count, dropped), in request order.
// A load inserts value after any equal entries and returns the new entry
// count; a load into a full store is discarded with dropped set. A query
// returns how many stored values are less than or equal to value. A clear
// empties the store and returns zero. Unused codes return the entry count.
// Each request travels down the chain one cell per cycle while the chain is
// not held, and its response beat leaves the last cell's register on rsp.
// One request is accepted every cycle unless rsp holds a beat that is not
// taken; the chain depth sets the latency, the compares and the increment
// in each cell set the clock rate.
// The last cell's register is the output register. While rsp holds a beat
// that is not taken, the whole chain holds and req.ready is low.
// Reset clears the entry count and empties the chain; no clearing pass is
// needed and a request can be taken in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_store_upper_bound_count_unit_macros.svh"

module sorted_store_upper_bound_count_unit #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssubc_req_if.sink   req,
	ssubc_rsp_if.source rsp
);
	import ssubc_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);

	ctl_t             ctl_c [0:CAPACITY];
	logic [KEY_W-1:0] key_c [0:CAPACITY];
	logic [CW-1:0]    n_c   [0:CAPACITY];
	logic [CW-1:0]    res_c [0:CAPACITY];

	logic [CW-1:0]         count_q;
	logic                  en;
	logic                  accept;
	logic                  full;
	logic [CW+COUNT_W-1:0] res_ext;

	assign en         = !rsp.valid || rsp.ready;
	assign req.ready  = en;
	assign accept     = req.valid && en;
	assign full       = count_q >= CAP_W;

	always_comb begin
		ctl_c[0]     = '0;
		ctl_c[0].vld = accept;
		key_c[0]     = $unsigned(req.value) ^ SIGN_FLIP;
		n_c[0]       = count_q;
		res_c[0]     = count_q;
		unique case (req.func)
			FUNC_LOAD: begin
				ctl_c[0].ins     = !full;
				ctl_c[0].dropped = full;
				res_c[0]         = full ? count_q : count_q + CW'(1);
			end
			FUNC_QUERY: begin
				ctl_c[0].qry = 1'b1;
				res_c[0]     = '0;
			end
			FUNC_CLEAR: begin
				res_c[0] = '0;
			end
			default: begin
				res_c[0] = count_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			unique case (req.func)
				FUNC_LOAD: begin
					if (!full) begin
						count_q <= count_q + CW'(1);
					end
				end
				FUNC_CLEAR: begin
					count_q <= '0;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ssubc_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (ctl_c[i]),
			.key_i  (key_c[i]),
			.n_i    (n_c[i]),
			.res_i  (res_c[i]),
			.ctl_o  (ctl_c[i+1]),
			.key_o  (key_c[i+1]),
			.n_o    (n_c[i+1]),
			.res_o  (res_c[i+1])
		);
	end

	assign res_ext     = {{COUNT_W{1'b0}}, res_c[CAPACITY]};
	assign rsp.valid   = ctl_c[CAPACITY].vld;
	assign rsp.count   = res_ext[COUNT_W-1:0];
	assign rsp.dropped = ctl_c[CAPACITY].dropped;

	`SSUBC_ASSERT_NEXT(a_clear_empties, accept && (req.func == FUNC_CLEAR),
		count_q == '0, "clear did not empty the store")
	`SSUBC_ASSERT_NEXT(a_load_counts, accept && (req.func == FUNC_LOAD) && !full,
		count_q == $past(count_q) + CW'(1), "load did not advance the entry count")
	`SSUBC_ASSERT_IMPL(a_drop_when_full, ctl_c[CAPACITY].vld && ctl_c[CAPACITY].dropped,
		(res_c[CAPACITY] == CAP_W) && !ctl_c[CAPACITY].qry, "dropped beat without a full store")
	`SSUBC_ASSERT_IMPL(a_insert_lands, ctl_c[CAPACITY].vld,
		!ctl_c[CAPACITY].ins, "insert left the chain without a slot")

endmodule

`default_nettype wire

@@ rtl/core/ssubc_cell.sv @@
// ----------------------------------------------------------------------------
// ssubc_cell
// One slot of the sorted chain. It holds one stored value and registers the
// beat passing through it, applying an insert step or a query count step.
// ----------------------------------------------------------------------------
`default_nettype none

module ssubc_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned CW  = 9
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire ssubc_pkg::ctl_t             ctl_i,
	input  wire logic [ssubc_pkg::KEY_W-1:0] key_i,
	input  wire logic [CW-1:0]               n_i,
	input  wire logic [CW-1:0]               res_i,
	output ssubc_pkg::ctl_t                  ctl_o,
	output logic [ssubc_pkg::KEY_W-1:0]      key_o,
	output logic [CW-1:0]                    n_o,
	output logic [CW-1:0]                    res_o
);
	import ssubc_pkg::*;

	localparam logic [CW-1:0] IDX_W = CW'(IDX);

	logic [KEY_W-1:0] val_q;
	ctl_t             ctl_q;
	logic [KEY_W-1:0] key_q;
	logic [CW-1:0]    n_q;
	logic [CW-1:0]    res_q;

	logic occupied;
	logic le;
	logic place;
	logic displace;
	logic hit;
	ctl_t ctl_nxt;

	always_comb begin
		occupied    = IDX_W < n_i;
		le          = val_q <= key_i;
		place       = ctl_i.vld && ctl_i.ins && (IDX_W == n_i);
		displace    = ctl_i.vld && ctl_i.ins && occupied && !le;
		hit         = ctl_i.vld && ctl_i.qry && occupied && le;
		ctl_nxt     = ctl_i;
		ctl_nxt.ins = ctl_i.ins && !place;
	end

	always_ff @(posedge clk) begin
		if (en && (place || displace)) begin
			val_q <= key_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			key_q <= displace ? val_q : key_i;
			n_q   <= n_i;
			res_q <= res_i + CW'(hit);
		end
	end

	assign ctl_o = ctl_q;
	assign key_o = key_q;
	assign n_o   = n_q;
	assign res_o = res_q;

endmodule

`default_nettype wire

@@ dv/sorted_store_upper_bound_count_checker.sv @@
// ----------------------------------------------------------------------------
// Sorted store response checker
// Watches the request and response channels of the sorted store unit. Every
// accepted request beat is applied to a local sorted copy of the store, which
// gives the expected count and dropped flag. Every accepted response beat is
// compared field by field with the oldest expected beat.
// ----------------------------------------------------------------------------
module sorted_store_upper_bound_count_checker #(
	parameter int unsigned CAPACITY = 256
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	ssubc_req_if        req,
	ssubc_rsp_if        rsp,
	output int unsigned mismatches,
	output int unsigned outstanding
);

	import ssubc_pkg::*;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic               dropped;
	} rsp_beat_t;

	logic signed [KEY_W-1:0] store_vals[$];
	rsp_beat_t               rsp_expected[$];

	function automatic logic [COUNT_W-1:0] count_le(input logic signed [KEY_W-1:0] key);
		int unsigned n;
		n = 0;
		foreach (store_vals[i])
			if (store_vals[i] <= key)
				n++;
		return COUNT_W'(n);
	endfunction

	function automatic rsp_beat_t apply_request(input logic [FUNC_W-1:0] func,
			input logic signed [KEY_W-1:0] value);
		rsp_beat_t   beat;
		int unsigned pos;
		beat.count   = COUNT_W'(store_vals.size());
		beat.dropped = 1'b0;
		case (func)
			FUNC_LOAD: begin
				if (store_vals.size() >= CAPACITY) begin
					beat.dropped = 1'b1;
				end else begin
					pos = 32'(count_le(value));
					store_vals.insert(pos, value);
				end
				beat.count = COUNT_W'(store_vals.size());
			end
			FUNC_QUERY: begin
				beat.count = count_le(value);
			end
			FUNC_CLEAR: begin
				store_vals.delete();
				beat.count = '0;
			end
			default: begin
			end
		endcase
		return beat;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_beat_t   want;
		rsp_beat_t   next_beat;
		int unsigned bad;
		if (!arst_n) begin
			store_vals.delete();
			rsp_expected.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready) begin
				next_beat = apply_request(req.func, req.value);
				rsp_expected.insert(rsp_expected.size(), next_beat);
			end
			if (rsp.valid && rsp.ready) begin
				if (rsp_expected.size() == 0) begin
					$display("%0t: response beat with none expected: count %0d dropped %0d",
						$time, rsp.count, rsp.dropped);
					mismatches <= mismatches + 1;
				end else begin
					want = rsp_expected.pop_front();
					bad  = 0;
					if (rsp.count !== want.count) begin
						$display("%0t: count expected %0d actual %0d",
							$time, want.count, rsp.count);
						bad++;
					end
					if (rsp.dropped !== want.dropped) begin
						$display("%0t: dropped expected %0d actual %0d",
							$time, want.dropped, rsp.dropped);
						bad++;
					end
					if (bad != 0)
						mismatches <= mismatches + 1;
				end
			end
			outstanding <= rsp_expected.size();
		end
	end

endmodule

@@ dv/sorted_store_upper_bound_count_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Sorted store unit testbench
// Drives loads, queries, clears and the spare function code into the sorted
// store unit with random gaps on both channels, fills the store past its
// capacity while the response side holds off for a long stretch, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module sorted_store_upper_bound_count_unit_tb;

	import ssubc_pkg::*;

	localparam int unsigned STORE_DEPTH = 256;
	localparam int unsigned CYCLE_LIMIT = 100000;
	localparam int unsigned LONG_HOLD   = 800;
	localparam int unsigned SETTLE      = STORE_DEPTH + 50;
	localparam int unsigned MIX_ITEMS   = 120;

	localparam logic [FUNC_W-1:0]       FUNC_SPARE = 2'd3;
	localparam logic signed [KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
	localparam logic signed [KEY_W-1:0] KEY_MAX    = 32'sh7fff_ffff;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned cycles;
	bit          send_steady;
	bit          hold_armed;
	bit          hold_taken;

	ssubc_req_if req_ch ();
	ssubc_rsp_if rsp_ch ();

	always #5 clk = ~clk;

	sorted_store_upper_bound_count_unit #(
		.CAPACITY(STORE_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	sorted_store_upper_bound_count_checker #(
		.CAPACITY(STORE_DEPTH)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_beat(input logic [FUNC_W-1:0] func,
			input logic signed [KEY_W-1:0] value);
		int unsigned gap;
		gap = send_steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func  <= func;
		req_ch.value <= value;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	function automatic logic signed [KEY_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6:    return $urandom_range(0, 15) - 8;
			7:          return KEY_MIN;
			8:          return KEY_MAX;
			default:    return $urandom_range(0, 1) ? KEY_MIN + 1 : KEY_MAX - 1;
		endcase
	endfunction

	function automatic logic [FUNC_W-1:0] draw_func();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 48)
			return FUNC_LOAD;
		else if (r < 88)
			return FUNC_QUERY;
		else if (r < 95)
			return FUNC_CLEAR;
		return FUNC_SPARE;
	endfunction

	initial begin : rsp_taker
		int unsigned stall;
		int unsigned beats;
		bit          steady;
		rsp_ch.ready = 1'b0;
		beats        = 0;
		steady       = 1'b0;
		wait (arst_n);
		forever begin
			if (beats % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (hold_armed && !hold_taken) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_taken = 1'b1;
			end else begin
				stall = steady ? 0 : $urandom_range(0, 5);
				if (stall != 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			beats++;
		end
	end

	initial begin : req_maker
		req_ch.valid = 1'b0;
		req_ch.func  = FUNC_LOAD;
		req_ch.value = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Edge values, equal entries, the spare code and clears.
		send_steady = 1'b0;
		send_beat(FUNC_QUERY, 0);
		send_beat(FUNC_LOAD, 0);
		send_beat(FUNC_LOAD, KEY_MIN);
		send_beat(FUNC_LOAD, KEY_MAX);
		send_beat(FUNC_LOAD, 0);
		send_beat(FUNC_LOAD, -1);
		send_beat(FUNC_QUERY, KEY_MIN);
		send_beat(FUNC_QUERY, KEY_MAX);
		send_beat(FUNC_QUERY, 0);
		send_beat(FUNC_QUERY, -1);
		send_beat(FUNC_QUERY, KEY_MIN + 1);
		send_beat(FUNC_SPARE, 32'shffff_ffff);
		send_beat(FUNC_SPARE, 0);
		send_beat(FUNC_CLEAR, 32'sh5a5a_a5a5);
		send_beat(FUNC_QUERY, KEY_MAX);
		send_beat(FUNC_LOAD, -5);
		send_beat(FUNC_LOAD, -5);
		send_beat(FUNC_QUERY, -5);
		send_beat(FUNC_QUERY, -6);
		send_beat(FUNC_CLEAR, 0);

		// Fill past capacity back to back while the response side holds off.
		send_steady = 1'b1;
		hold_armed  = 1'b1;
		repeat (STORE_DEPTH) send_beat(FUNC_LOAD, draw_value());
		repeat (6) send_beat(FUNC_LOAD, draw_value());
		send_beat(FUNC_QUERY, KEY_MIN);
		send_beat(FUNC_QUERY, KEY_MAX);
		repeat (6) send_beat(FUNC_QUERY, draw_value());
		send_beat(FUNC_SPARE, draw_value());
		send_beat(FUNC_CLEAR, draw_value());

		for (int i = 0; i < MIX_ITEMS; i++) begin
			if (i % 30 == 0)
				send_steady = ($urandom_range(0, 2) == 0);
			send_beat(draw_func(), draw_value());
		end
		req_ch.valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
